[design/lbkc_pkg.sv]
package lbkc_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int KEY_BITS      = 64;
  localparam int ITEM_KEY_W    = 64;
  localparam int COUNT_W       = 32;
  localparam int USED_W        = 7;
  localparam int OCC_W         = $clog2(TABLE_ENTRIES + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [OCC_W-1:0]    occ_t;

  typedef struct packed {
    key_t   key;
    count_t count;
  } entry_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic cmp_en;
    logic shift;
    logic used;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_MATCH  = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  function automatic count_t sat_inc(input count_t v);
    sat_inc = (v == COUNT_MAX) ? v : v + COUNT_ONE;
  endfunction

endpackage

[design/lru_bounded_key_counter.sv]
// LRU-bounded key counter.
// Input channel: item_key with in_valid / in_stall. Output channel: one result
// transaction per input (was_hit, new_count, did_evict, evicted_key,
// evicted_count, lookups_total, hits_total, entries_used) with out_valid /
// out_stall.
// The table is a chain of cells kept in recency order, cell 0 most recent.
// Each item runs in order: accept and register the key, compare it in all
// cells at once, then shift the chain (move-to-front) and load the result.
// One item is in flight at a time: a new item is not accepted until the last
// one has committed its result. The update step waits while a previous
// result is still held under out_stall; in_stall stays high until it commits.
// A new item can be accepted while a finished result waits to be taken.
// Reset clears the occupancy count, both totals and the handshake state; cell
// contents are not cleared, a cell only counts once occupancy covers it.
// The least recent entry is the last used cell, evicted once all cells are used.
module lru_bounded_key_counter import lbkc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ITEM_KEY_W-1:0] item_key,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  was_hit,
  output logic [COUNT_W-1:0]    new_count,
  output logic                  did_evict,
  output logic [ITEM_KEY_W-1:0] evicted_key,
  output logic [COUNT_W-1:0]    evicted_count,
  output logic [COUNT_W-1:0]    lookups_total,
  output logic [COUNT_W-1:0]    hits_total,
  output logic [USED_W-1:0]     entries_used
);

  state_t state, state_next;
  key_t   key_q;
  occ_t   occ, occ_next;
  count_t lookup_tally, hit_tally;

  entry_t    ent   [TABLE_ENTRIES];
  logic      [TABLE_ENTRIES-1:0] match;
  logic      [TABLE_ENTRIES-1:0] shift;
  cell_ctl_t ctl   [TABLE_ENTRIES];
  entry_t    head;

  logic   hit, full, evict, out_free, commit;
  count_t hit_count;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign commit   = (state == ST_UPDATE) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_MATCH;
      ST_MATCH:  state_next = ST_UPDATE;
      ST_UPDATE: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  assign hit   = |match;
  assign full  = (occ == occ_t'(TABLE_ENTRIES));
  assign evict = !hit && full;

  always_comb begin
    hit_count = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_count = hit_count | (match[i] ? ent[i].count : '0);
    end
  end

  assign head.key   = key_q;
  assign head.count = hit ? sat_inc(hit_count) : COUNT_ONE;

  assign occ_next = (!hit && !full) ? occ + occ_t'(1) : occ;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    // cell moves when the hit is at or behind it, or on any miss
    assign shift[i]      = !hit || (|(match >> i));
    assign ctl[i].cmp_en = (state == ST_MATCH);
    assign ctl[i].shift  = commit && shift[i];
    assign ctl[i].used   = (occ > occ_t'(i));

    lbkc_cell u_cell (
      .clk     (clk),
      .ctl     (ctl[i]),
      .cmp_key (key_q),
      .prev    ((i == 0) ? head : ent[(i == 0) ? 0 : i - 1]),
      .ent     (ent[i]),
      .match   (match[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      occ          <= '0;
      lookup_tally <= '0;
      hit_tally    <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        occ          <= occ_next;
        lookup_tally <= sat_inc(lookup_tally);
        if (hit) begin
          hit_tally <= sat_inc(hit_tally);
        end
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      key_q <= item_key[KEY_BITS-1:0];
    end
    if (commit) begin
      was_hit       <= hit;
      new_count     <= head.count;
      did_evict     <= evict;
      evicted_key   <= evict ? ITEM_KEY_W'(ent[TABLE_ENTRIES-1].key) : '0;
      evicted_count <= evict ? ent[TABLE_ENTRIES-1].count : '0;
      lookups_total <= sat_inc(lookup_tally);
      hits_total    <= hit ? sat_inc(hit_tally) : hit_tally;
      entries_used  <= USED_W'(occ_next);
    end
  end

endmodule

[design/lbkc_cell.sv]
module lbkc_cell import lbkc_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  key_t      cmp_key,
  input  entry_t    prev,
  output entry_t    ent,
  output logic      match
);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      ent <= prev;
    end
    // unused cells never match, so stale contents are harmless
    if (ctl.cmp_en) begin
      match <= ctl.used && (ent.key == cmp_key);
    end
  end

endmodule

[design/lbkc_checker.sv]
module lbkc_sva import lbkc_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  was_hit,
  input logic [COUNT_W-1:0]    new_count,
  input logic                  did_evict,
  input logic [ITEM_KEY_W-1:0] evicted_key,
  input logic [COUNT_W-1:0]    evicted_count,
  input logic [USED_W-1:0]     entries_used
);

  // held result stays valid with new_count and evicted_key stable
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(new_count) && $stable(evicted_key))
    else $error("stalled output changed");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_hit |-> !did_evict)
    else $error("hit reported together with eviction");

  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && did_evict |-> entries_used == USED_W'(TABLE_ENTRIES) && new_count == COUNT_ONE)
    else $error("eviction without full table or fresh count");

  a_no_evict_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !did_evict |-> evicted_key == '0 && evicted_count == '0)
    else $error("eviction fields set without eviction");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("handshake not cleared by reset");

endmodule

bind lru_bounded_key_counter lbkc_sva u_lbkc_sva (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .was_hit       (was_hit),
  .new_count     (new_count),
  .did_evict     (did_evict),
  .evicted_key   (evicted_key),
  .evicted_count (evicted_count),
  .entries_used  (entries_used)
);
